FILE: design/cfst_pkg.sv
// Shared types, constants and helpers for the CAN frame to slcan text encoder.
package cfst_pkg;

   localparam int IdWidth      = 29;
   localparam int DlcWidth     = 4;
   localparam int PayloadWidth = 64;
   localparam int CharWidth    = 8;
   localparam int CntWidth     = 4;

   localparam logic [DlcWidth-1:0]  MaxBytes   = 4'd8;
   localparam logic [CntWidth-1:0]  StdIdLast  = 4'd2;
   localparam logic [CntWidth-1:0]  ExtIdLast  = 4'd7;
   localparam logic [CharWidth-1:0] CharCr     = 8'h0D;
   localparam logic [CharWidth-1:0] CharLowR   = 8'h72;
   localparam logic [CharWidth-1:0] CharLowT   = 8'h74;
   localparam logic [CharWidth-1:0] CaseOffset = 8'd32;
   localparam logic [CharWidth-1:0] DigitBase  = 8'h30;
   localparam logic [CharWidth-1:0] AlphaBase  = 8'h37;
   localparam logic [3:0]           NibbleTen  = 4'hA;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TYPE,
      ST_ID,
      ST_LEN,
      ST_DATA,
      ST_CR
   } state_type;

   typedef enum logic [2:0] {
      CNT_HOLD,
      CNT_ZERO,
      CNT_DEC,
      CNT_INC
   } cnt_op_type;

   typedef enum logic [2:0] {
      SEL_TYPE,
      SEL_ID,
      SEL_LEN,
      SEL_DATA,
      SEL_CR
   } char_sel_type;

   typedef struct packed {
      logic         load;
      cnt_op_type   cnt_op;
      char_sel_type sel;
   } dp_cmd_type;

   typedef struct packed {
      logic id_last;
      logic len_zero;
      logic data_last;
   } dp_status_type;

   function automatic logic [CharWidth-1:0] hex_char(input logic [3:0] nib);
      if (nib < NibbleTen)
         return DigitBase + {4'd0, nib};
      else
         return AlphaBase + {4'd0, nib};
   endfunction

endpackage

FILE: design/cfst_ctrl.sv
// Sequencer that walks the fields of one slcan line, one character per transfer.
module cfst_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_last,
   input  cfst_pkg::dp_status_type status,
   output cfst_pkg::dp_cmd_type    cmd
);
   import cfst_pkg::*;

   state_type state_ff, state_in;
   logic      advance;

   assign advance = (state_ff != ST_IDLE) && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_TYPE;
         ST_TYPE: if (advance) state_in = ST_ID;
         ST_ID:   if (advance && status.id_last) state_in = ST_LEN;
         ST_LEN: begin
            if (advance)
               state_in = status.len_zero ? ST_CR : ST_DATA;
         end
         ST_DATA: if (advance && status.data_last) state_in = ST_CR;
         ST_CR: begin
            if (advance)
               state_in = req_valid ? ST_TYPE : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      rsp_valid  = 1'b1;
      rsp_last   = 1'b0;
      cmd.cnt_op = CNT_HOLD;
      cmd.sel    = SEL_TYPE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            rsp_valid = 1'b0;
         end
         ST_TYPE: cmd.sel = SEL_TYPE;
         ST_ID: begin
            cmd.sel = SEL_ID;
            if (advance)
               cmd.cnt_op = status.id_last ? CNT_ZERO : CNT_DEC;
         end
         ST_LEN: cmd.sel = SEL_LEN;
         ST_DATA: begin
            cmd.sel = SEL_DATA;
            if (advance)
               cmd.cnt_op = CNT_INC;
         end
         ST_CR: begin
            cmd.sel   = SEL_CR;
            rsp_last  = 1'b1;
            req_ready = rsp_ready;
         end
         default: rsp_valid = 1'b0;
      endcase
      cmd.load = req_valid && req_ready;
   end

endmodule

FILE: design/cfst_dp.sv
// Frame registers, digit counter and character select for the slcan encoder.
module cfst_dp (
   input  logic                                clock,
   input  logic [cfst_pkg::IdWidth-1:0]        req_frame_id,
   input  logic                                req_extended,
   input  logic                                req_remote,
   input  logic [cfst_pkg::DlcWidth-1:0]       req_dlc,
   input  logic [cfst_pkg::PayloadWidth-1:0]   req_payload,
   input  cfst_pkg::dp_cmd_type                 cmd,
   output cfst_pkg::dp_status_type              status,
   output logic [cfst_pkg::CharWidth-1:0]      rsp_text_char
);
   import cfst_pkg::*;

   logic [IdWidth-1:0]      id_ff;
   logic                    ext_ff;
   logic                    rtr_ff;
   logic [DlcWidth-1:0]     len_ff;
   logic [PayloadWidth-1:0] data_ff;
   logic [CntWidth-1:0]     cnt_ff, cnt_in;
   logic [DlcWidth-1:0]     len_m1;
   logic [31:0]             id_wide;
   logic [3:0]              id_nib;
   logic [3:0]              data_nib;
   logic [CharWidth-1:0]    type_char;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff   <= req_frame_id;
         ext_ff  <= req_extended;
         rtr_ff  <= req_remote;
         len_ff  <= (req_dlc > MaxBytes) ? MaxBytes : req_dlc;
         data_ff <= req_payload;
      end
      cnt_ff <= cnt_in;
   end

   always_comb begin
      case (cmd.cnt_op)
         CNT_ZERO: cnt_in = '0;
         CNT_DEC:  cnt_in = cnt_ff - 1'b1;
         CNT_INC:  cnt_in = cnt_ff + 1'b1;
         default:  cnt_in = cnt_ff;
      endcase
      // first id digit index, taken straight from the input on a load
      if (cmd.load)
         cnt_in = req_extended ? ExtIdLast : StdIdLast;
   end

   assign len_m1           = len_ff - 1'b1;
   assign status.id_last   = (cnt_ff == '0);
   assign status.len_zero  = (len_ff == '0);
   // last nibble index is 2*len-1
   assign status.data_last = (cnt_ff == {len_m1[2:0], 1'b1});

   assign id_wide  = {{(32-IdWidth){1'b0}}, id_ff};
   assign id_nib   = id_wide[cnt_ff[2:0]*4 +: 4];
   // high nibble of a byte comes first
   assign data_nib = data_ff[{cnt_ff[3:1], ~cnt_ff[0]}*4 +: 4];

   always_comb begin
      type_char = rtr_ff ? CharLowR : CharLowT;
      if (ext_ff)
         type_char = type_char - CaseOffset;
   end

   always_comb begin
      unique case (cmd.sel)
         SEL_TYPE: rsp_text_char = type_char;
         SEL_ID:   rsp_text_char = hex_char(id_nib);
         SEL_LEN:  rsp_text_char = hex_char(len_ff);
         SEL_DATA: rsp_text_char = hex_char(data_nib);
         SEL_CR:   rsp_text_char = CharCr;
         default:  rsp_text_char = CharCr;
      endcase
   end

endmodule

FILE: design/can_frame_to_slcan_text_core.sv
// Top level of the CAN frame to slcan ASCII line encoder.
//
//   channel | direction | ports
//   --------+-----------+---------------------------------------------------
//   req     | in        | frame_id[28:0] extended remote dlc[3:0] payload[63:0]
//   rsp     | out       | text_char[7:0] last
//
// One character per cycle while rsp_ready is high: a line is 2*len + id digits + 3 characters (6 to 27).
// The next frame is taken in the cycle its predecessor's carriage return transfers,
// so frames stream with no gap; the line sequencer handles one frame at a time.
// A stalled rsp_ready holds the current character and the sequencer.
// Reset (synchronous, active high) returns the sequencer to idle.
module can_frame_to_slcan_text_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [cfst_pkg::IdWidth-1:0]        req_frame_id,
   input  logic                                req_extended,
   input  logic                                req_remote,
   input  logic [cfst_pkg::DlcWidth-1:0]       req_dlc,
   input  logic [cfst_pkg::PayloadWidth-1:0]   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cfst_pkg::CharWidth-1:0]      rsp_text_char,
   output logic                                rsp_last
);
   import cfst_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   cfst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_last  (rsp_last),
      .status    (status),
      .cmd       (cmd)
   );

   cfst_dp u_dp (
      .clock         (clock),
      .req_frame_id  (req_frame_id),
      .req_extended  (req_extended),
      .req_remote    (req_remote),
      .req_dlc       (req_dlc),
      .req_payload   (req_payload),
      .cmd           (cmd),
      .status        (status),
      .rsp_text_char (rsp_text_char)
   );

   // a new frame always opens with its type letter
   a_accept_starts_line: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid && !rsp_last)
      else $error("accepted frame did not start a line");

   // no frame taken in the middle of a line
   a_no_accept_mid_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("frame accepted mid line");

   // line ends and nothing waits: go idle
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last && !req_valid |=> !rsp_valid)
      else $error("output stayed valid after the line ended");

   // stalled character holds
   a_stall_holds_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_text_char) && $stable(rsp_last))
      else $error("character changed under a stall");

endmodule

FILE: tb/sv/can_frame_to_slcan_text_core_tb.sv
// Self-checking testbench for the CAN frame to slcan text line encoder.
`timescale 1ns / 100ps

module can_frame_to_slcan_text_core_tb;
   import cfst_pkg::*;

   localparam int unsigned MaxWait     = 18;
   localparam int unsigned RandFrames  = 260;
   localparam int unsigned HoldAtChar  = 900;
   localparam int unsigned HoldCycles  = 400;
   localparam int unsigned QuietLimit  = 4000;
   localparam int unsigned DrainCycles = 60;
   localparam int unsigned MaxReports  = 10;

   typedef struct {
      logic [IdWidth-1:0]      frame_id;
      logic                    extended;
      logic                    remote;
      logic [DlcWidth-1:0]     dlc;
      logic [PayloadWidth-1:0] payload;
   } frame_type;

   typedef struct {
      logic [CharWidth-1:0] text_char;
      logic                 last;
   } line_char_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [IdWidth-1:0]      req_frame_id = '0;
   logic                    req_extended = 1'b0;
   logic                    req_remote = 1'b0;
   logic [DlcWidth-1:0]     req_dlc = '0;
   logic [PayloadWidth-1:0] req_payload = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [CharWidth-1:0]    rsp_text_char;
   logic                    rsp_last;

   frame_type      pending_frames[$];
   line_char_type  expected_chars[$];

   // transfer flags from the last rising edge, read by the falling-edge processes
   logic        req_done = 1'b0;
   logic        rsp_done = 1'b0;

   int unsigned total_frames;
   int unsigned frames_sent;
   int unsigned frames_accepted;
   int unsigned chars_received;
   int unsigned mismatches;
   int unsigned quiet_cycles;
   int unsigned send_gap;
   int unsigned recv_wait;
   int unsigned hold_left;
   int unsigned ext_frames, remote_frames, clamped_frames, lines_done;

   can_frame_to_slcan_text_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_frame_id  (req_frame_id),
      .req_extended  (req_extended),
      .req_remote    (req_remote),
      .req_dlc       (req_dlc),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_text_char (rsp_text_char),
      .rsp_last      (rsp_last)
   );

   always #4 clock = ~clock;

   function automatic logic [CharWidth-1:0] nibble_ascii(logic [3:0] nib);
      if (nib < 4'd10)
         return 8'h30 + 8'(nib);
      else
         return 8'h41 + 8'(nib) - 8'd10;
   endfunction

   function automatic void push_char(logic [CharWidth-1:0] ch, logic is_last);
      line_char_type c;
      c.text_char = ch;
      c.last      = is_last;
      expected_chars.push_back(c);
   endfunction

   // Expected slcan line for one frame, one entry per character.
   function automatic void encode_frame(frame_type f);
      logic [3:0]  n_bytes;
      logic [7:0]  kind;
      logic [7:0]  data_byte;
      logic [31:0] wide_id;
      int          digits;
      n_bytes = (f.dlc > MaxBytes) ? MaxBytes : f.dlc;
      kind    = f.remote ? CharLowR : CharLowT;
      if (f.extended)
         kind = kind - CaseOffset;
      push_char(kind, 1'b0);
      wide_id = {3'b000, f.frame_id};
      digits  = f.extended ? 8 : 3;
      for (int i = digits - 1; i >= 0; i--)
         push_char(nibble_ascii(4'(wide_id >> (4 * i))), 1'b0);
      push_char(nibble_ascii(n_bytes), 1'b0);
      for (int k = 0; k < int'(n_bytes); k++) begin
         data_byte = 8'(f.payload >> (8 * k));
         push_char(nibble_ascii(data_byte[7:4]), 1'b0);
         push_char(nibble_ascii(data_byte[3:0]), 1'b0);
      end
      push_char(CharCr, 1'b1);
   endfunction

   function automatic int unsigned draw_wait(bit no_idle);
      if (no_idle || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, MaxWait);
   endfunction

   task automatic add_frame(logic [IdWidth-1:0] id, logic ext, logic rtr,
                            logic [DlcWidth-1:0] dlc, logic [PayloadWidth-1:0] data);
      frame_type f;
      f.frame_id = id;
      f.extended = ext;
      f.remote   = rtr;
      f.dlc      = dlc;
      f.payload  = data;
      pending_frames.push_back(f);
   endtask

   // Sender: one frame per transfer, random gap drawn after each transfer.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap   = draw_wait(1'b0);
      end else if (!req_valid || req_done) begin
         if (req_valid)
            send_gap = draw_wait((frames_sent / 32) % 4 == 3);
         if (send_gap == 0 && pending_frames.size() != 0) begin
            req_valid    <= 1'b1;
            req_frame_id <= pending_frames[0].frame_id;
            req_extended <= pending_frames[0].extended;
            req_remote   <= pending_frames[0].remote;
            req_dlc      <= pending_frames[0].dlc;
            req_payload  <= pending_frames[0].payload;
            void'(pending_frames.pop_front());
            frames_sent++;
         end else begin
            req_valid <= 1'b0;
            if (send_gap > 0)
               send_gap--;
         end
      end
   end

   // Receiver: random stall per character, plus one long hold-off mid run.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait  = 0;
         hold_left  = 0;
      end else begin
         if (rsp_done) begin
            recv_wait = draw_wait((chars_received / 200) % 4 == 3);
            if (chars_received == HoldAtChar)
               hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: predict on input transfers, check on output transfers.
   always @(posedge clock) begin
      frame_type     f;
      line_char_type exp_c;
      req_done <= !reset && req_valid && req_ready;
      rsp_done <= !reset && rsp_valid && rsp_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            f.frame_id = req_frame_id;
            f.extended = req_extended;
            f.remote   = req_remote;
            f.dlc      = req_dlc;
            f.payload  = req_payload;
            encode_frame(f);
            frames_accepted++;
            ext_frames     += f.extended;
            remote_frames  += f.remote;
            clamped_frames += (f.dlc > MaxBytes);
         end
         if (rsp_valid && rsp_ready) begin
            chars_received++;
            lines_done += rsp_last;
            if (expected_chars.size() == 0) begin
               mismatches++;
               if (mismatches <= MaxReports)
                  $display("ERROR: unexpected char 0x%02h last=%0b",
                           rsp_text_char, rsp_last);
            end else begin
               exp_c = expected_chars.pop_front();
               if (rsp_text_char !== exp_c.text_char || rsp_last !== exp_c.last) begin
                  mismatches++;
                  if (mismatches <= MaxReports)
                     $display("ERROR: char %0d: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                              chars_received, exp_c.text_char, exp_c.last,
                              rsp_text_char, rsp_last);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("ERROR: no transfer for %0d cycles", quiet_cycles);
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      logic [3:0] dlc_r;
      // directed: id extremes, both frame kinds, every length, clamp, masked bits
      add_frame(29'h0, 1'b0, 1'b0, 4'd0, 64'h0);
      add_frame(29'h7FF, 1'b0, 1'b0, 4'd1, 64'hFF);
      add_frame(29'h1FFF_FFFF, 1'b0, 1'b0, 4'd2, 64'hFFFF_FFFF_FFFF_FFFF);
      add_frame(29'h1FFF_F123, 1'b0, 1'b1, 4'd3, 64'h0);
      add_frame(29'h0, 1'b1, 1'b0, 4'd0, 64'h0);
      add_frame(29'h1FFF_FFFF, 1'b1, 1'b0, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
      add_frame(29'h1234_5678 & 29'h1FFF_FFFF, 1'b1, 1'b1, 4'd8,
                64'hFEDC_BA98_7654_3210);
      add_frame(29'h0ABC_DEF0, 1'b1, 1'b1, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      add_frame(29'h0000_0ABC, 1'b0, 1'b1, 4'd4, 64'h0123_4567_89AB_CDEF);
      add_frame(29'h0000_0DEF, 1'b0, 1'b0, 4'd5, 64'hA5A5_5A5A_0F0F_F0F0);
      add_frame(29'h1555_5555, 1'b1, 1'b0, 4'd6, 64'h5555_5555_5555_5555);
      add_frame(29'h0AAA_AAAA, 1'b1, 1'b0, 4'd7, 64'hAAAA_AAAA_AAAA_AAAA);
      add_frame(29'h0000_0123, 1'b0, 1'b0, 4'd9, 64'h1122_3344_5566_7788);
      add_frame(29'h1000_0000, 1'b1, 1'b0, 4'd12, 64'h8000_0000_0000_0001);
      add_frame(29'h0000_0FFF, 1'b0, 1'b1, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
      add_frame(29'h1FFF_FFFF, 1'b1, 1'b1, 4'd15, 64'h0);
      add_frame(29'h0000_0800, 1'b0, 1'b0, 4'd10, 64'h0);
      add_frame(29'h0000_0001, 1'b1, 1'b0, 4'd11, 64'hDEAD_BEEF_CAFE_F00D);
      add_frame(29'h0000_0456, 1'b0, 1'b1, 4'd13, 64'h9999_AAAA_BBBB_CCCC);
      add_frame(29'h0F0F_0F0F, 1'b1, 1'b0, 4'd14, 64'h0000_0000_FFFF_FFFF);
      for (int n = 0; n < RandFrames; n++) begin
         dlc_r = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8));
         add_frame(29'($urandom), 1'($urandom), 1'($urandom_range(0, 3) == 0),
                   dlc_r, {$urandom, $urandom});
      end
      total_frames = pending_frames.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (frames_accepted < total_frames || expected_chars.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("tb: %0d frames (%0d extended, %0d remote, %0d length-clamped), %0d lines",
               frames_accepted, ext_frames, remote_frames, clamped_frames, lines_done);
      $display("tb: %0d characters checked, %0d mismatches, %0d left unmatched",
               chars_received, mismatches, expected_chars.size());
      if (mismatches == 0 && expected_chars.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
